### sv/trial_division_prime_test_macros.svh
// assertion macros used by the trial division prime test back end
`ifndef TRIAL_DIVISION_PRIME_TEST_MACROS_SVH
`define TRIAL_DIVISION_PRIME_TEST_MACROS_SVH

// same-cycle implication, checked out of reset
`define TDPT_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("tdpt assertion failed");

// next-cycle implication, checked out of reset
`define TDPT_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("tdpt assertion failed");

`endif

### sv/tdpt_pkg.sv
// package: types and constants of the trial division prime test
`default_nettype none
package tdpt_pkg;

	localparam int NUM_WIDTH_DEF = 16;
	localparam int QUEUE_DEPTH   = 2;

	localparam logic [1:0] VERDICT_PRIME     = 2'd0;
	localparam logic [1:0] VERDICT_NEITHER   = 2'd1;
	localparam logic [1:0] VERDICT_COMPOSITE = 2'd2;

	// class of a number as sorted by the front end
	typedef enum logic [1:0] {
		KIND_NEITHER,
		KIND_TWO,
		KIND_EVEN,
		KIND_ODD
	} kind_t;

	localparam int KIND_WIDTH = $bits(kind_t);

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_CHECK
	} bk_state_t;

endpackage
`default_nettype wire

### sv/tdpt_front.sv
// front end: takes a number, sorts it into a class and registers it
`default_nettype none
module tdpt_front #(
	parameter int NUM_WIDTH = tdpt_pkg::NUM_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [NUM_WIDTH-1:0] number,
	output logic                      f_valid,
	input  wire logic                 f_stall,
	output tdpt_pkg::kind_t           f_kind,
	output logic [NUM_WIDTH-1:0]      f_num
);

	logic                 valid_s1;
	tdpt_pkg::kind_t      kind_s1;
	logic [NUM_WIDTH-1:0] num_s1;
	tdpt_pkg::kind_t      kind_c;
	logic                 accept;

	always_comb begin
		if (number[NUM_WIDTH-1:1] == '0) begin
			kind_c = tdpt_pkg::KIND_NEITHER;
		end else if (number == NUM_WIDTH'(2)) begin
			kind_c = tdpt_pkg::KIND_TWO;
		end else if (!number[0]) begin
			kind_c = tdpt_pkg::KIND_EVEN;
		end else begin
			kind_c = tdpt_pkg::KIND_ODD;
		end
	end

	assign in_stall = valid_s1 && f_stall;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (!f_stall) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_s1 <= kind_c;
			num_s1  <= number;
		end
	end

	assign f_valid = valid_s1;
	assign f_kind  = kind_s1;
	assign f_num   = num_s1;

endmodule
`default_nettype wire

### sv/tdpt_queue.sv
// short queue between the front end and the search engine
`default_nettype none
module tdpt_queue #(
	parameter int DATA_WIDTH = tdpt_pkg::NUM_WIDTH_DEF + tdpt_pkg::KIND_WIDTH
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  wr_valid,
	output logic                       wr_stall,
	input  wire logic [DATA_WIDTH-1:0] wr_data,
	output logic                       rd_valid,
	input  wire logic                  rd_stall,
	output logic [DATA_WIDTH-1:0]      rd_data
);

	localparam int PTR_WIDTH = $clog2(tdpt_pkg::QUEUE_DEPTH);
	localparam int CNT_WIDTH = $clog2(tdpt_pkg::QUEUE_DEPTH + 1);

	logic [DATA_WIDTH-1:0] mem_q [tdpt_pkg::QUEUE_DEPTH];
	logic [PTR_WIDTH-1:0]  wr_ptr_q;
	logic [PTR_WIDTH-1:0]  rd_ptr_q;
	logic [CNT_WIDTH-1:0]  cnt_q;
	logic                  push;
	logic                  pop;

	assign wr_stall = (cnt_q == CNT_WIDTH'(tdpt_pkg::QUEUE_DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign push     = wr_valid && !wr_stall;
	assign pop      = rd_valid && !rd_stall;
	assign rd_data  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_WIDTH'(tdpt_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + PTR_WIDTH'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_WIDTH'(tdpt_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + PTR_WIDTH'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CNT_WIDTH'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CNT_WIDTH'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

endmodule
`default_nettype wire

### sv/tdpt_back.sv
// back end: trial division search with a bit-serial divider, result register
`default_nettype none
`include "trial_division_prime_test_macros.svh"
module tdpt_back #(
	parameter int NUM_WIDTH = tdpt_pkg::NUM_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 q_valid,
	output logic                      q_stall,
	input  wire tdpt_pkg::kind_t      q_kind,
	input  wire logic [NUM_WIDTH-1:0] q_num,
	output logic                      res_valid,
	input  wire logic                 res_stall,
	output logic [1:0]                res_verdict,
	output logic [NUM_WIDTH-2:0]      res_divisor
);

	localparam int CW = $clog2(NUM_WIDTH);
	localparam int DW = NUM_WIDTH - 1;

	tdpt_pkg::bk_state_t  state_q;
	tdpt_pkg::bk_state_t  state_d;
	logic [CW-1:0]        cnt_q;
	logic [NUM_WIDTH-1:0] n_q;
	logic [NUM_WIDTH-1:0] dq_q;
	logic [NUM_WIDTH-1:0] rem_q;
	logic [NUM_WIDTH-1:0] d_q;
	logic                 out_valid_q;
	logic [1:0]           verdict_q;
	logic [DW-1:0]        divisor_q;

	logic                 out_free;
	logic                 pop;
	logic                 start;
	logic                 retry;
	logic                 ld_out;
	logic [1:0]           verdict_d;
	logic [DW-1:0]        divisor_d;
	logic                 last_bit;
	logic                 found_prime;
	logic                 found_div;
	logic [NUM_WIDTH:0]   rem_shift;
	logic [NUM_WIDTH:0]   rem_sub;
	logic                 q_bit;

	assign out_free    = !out_valid_q || !res_stall;
	assign last_bit    = (cnt_q == CW'(NUM_WIDTH - 1));
	// quotient below trial divisor means d*d > n, search is over
	assign found_prime = (dq_q < d_q);
	assign found_div   = (rem_q == '0);

	// restoring division, one quotient bit per cycle
	assign rem_shift = {rem_q, dq_q[NUM_WIDTH-1]};
	assign rem_sub   = rem_shift - {1'b0, d_q};
	assign q_bit     = (rem_shift >= {1'b0, d_q});

	always_comb begin
		state_d = state_q;
		case (state_q)
			tdpt_pkg::BK_IDLE: begin
				if (q_valid && out_free && q_kind == tdpt_pkg::KIND_ODD) begin
					state_d = tdpt_pkg::BK_DIV;
				end
			end
			tdpt_pkg::BK_DIV: begin
				if (last_bit) begin
					state_d = tdpt_pkg::BK_CHECK;
				end
			end
			tdpt_pkg::BK_CHECK: begin
				if (found_prime || found_div) begin
					if (out_free) begin
						state_d = tdpt_pkg::BK_IDLE;
					end
				end else begin
					state_d = tdpt_pkg::BK_DIV;
				end
			end
			default: begin
				state_d = tdpt_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		pop       = 1'b0;
		start     = 1'b0;
		retry     = 1'b0;
		ld_out    = 1'b0;
		verdict_d = tdpt_pkg::VERDICT_PRIME;
		divisor_d = '0;
		case (state_q)
			tdpt_pkg::BK_IDLE: begin
				pop = q_valid && out_free;
				if (pop) begin
					case (q_kind)
						tdpt_pkg::KIND_NEITHER: begin
							ld_out    = 1'b1;
							verdict_d = tdpt_pkg::VERDICT_NEITHER;
							divisor_d = DW'(1);
						end
						tdpt_pkg::KIND_TWO: begin
							ld_out    = 1'b1;
							verdict_d = tdpt_pkg::VERDICT_PRIME;
						end
						tdpt_pkg::KIND_EVEN: begin
							ld_out    = 1'b1;
							verdict_d = tdpt_pkg::VERDICT_COMPOSITE;
							divisor_d = DW'(2);
						end
						tdpt_pkg::KIND_ODD: begin
							start = 1'b1;
						end
						default: begin
						end
					endcase
				end
			end
			tdpt_pkg::BK_CHECK: begin
				if (found_prime) begin
					ld_out    = out_free;
					verdict_d = tdpt_pkg::VERDICT_PRIME;
				end else if (found_div) begin
					ld_out    = out_free;
					verdict_d = tdpt_pkg::VERDICT_COMPOSITE;
					divisor_d = dq_q[DW-1:0];
				end else begin
					retry = 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign q_stall = !pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= tdpt_pkg::BK_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (start || retry) begin
				cnt_q <= '0;
			end else if (state_q == tdpt_pkg::BK_DIV) begin
				cnt_q <= cnt_q + CW'(1);
			end
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (!res_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q   <= q_num;
			dq_q  <= q_num;
			rem_q <= '0;
			d_q   <= NUM_WIDTH'(3);
		end else if (retry) begin
			dq_q  <= n_q;
			rem_q <= '0;
			d_q   <= d_q + NUM_WIDTH'(2);
		end else if (state_q == tdpt_pkg::BK_DIV) begin
			dq_q  <= {dq_q[NUM_WIDTH-2:0], q_bit};
			rem_q <= q_bit ? rem_sub[NUM_WIDTH-1:0] : rem_shift[NUM_WIDTH-1:0];
		end
		if (ld_out) begin
			verdict_q <= verdict_d;
			divisor_q <= divisor_d;
		end
	end

	assign res_valid   = out_valid_q;
	assign res_verdict = verdict_q;
	assign res_divisor = divisor_q;

	`TDPT_ASSERT_NXT(a_div_runs, clk, arst_n,
		state_q == tdpt_pkg::BK_DIV && !last_bit, state_q == tdpt_pkg::BK_DIV)
	`TDPT_ASSERT_IMP(a_trial_odd, clk, arst_n,
		state_q == tdpt_pkg::BK_DIV, d_q[0] && d_q != NUM_WIDTH'(1))
	`TDPT_ASSERT_NXT(a_retry_step, clk, arst_n,
		retry, state_q == tdpt_pkg::BK_DIV && d_q == $past(d_q) + NUM_WIDTH'(2))
	`TDPT_ASSERT_IMP(a_load_free, clk, arst_n, ld_out, out_free)

endmodule
`default_nettype wire

### sv/trial_division_prime_test.sv
// top level: trial division prime test, front end, queue and search engine
//
//   channel  signals                      direction  accepted when
//   in       in_valid in_stall number     input      in_valid && !in_stall
//   out      out_valid out_stall verdict  output     out_valid && !out_stall
//            divisor
//
// an input word goes through the front register and then the queue.
// 0, 1, 2 and even numbers are answered from the queue head with no search.
// an odd number is tried against the odd divisors from 3 up to sqrt(number); each
// trial divisor takes one full bit-serial division followed by a check.
// reset clears all control state at once; no clearing pass.
// a stalled output holds the back end: it pops no new number and a finished search
// waits with its result; the queue and front register then fill and in_stall rises.
`default_nettype none
module trial_division_prime_test #(
	parameter int NUM_WIDTH = tdpt_pkg::NUM_WIDTH_DEF
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [NUM_WIDTH-1:0] number,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [1:0]                verdict,
	output logic [NUM_WIDTH-2:0]      divisor
);

	localparam int QW = NUM_WIDTH + tdpt_pkg::KIND_WIDTH;

	logic                 f_valid;
	logic                 f_stall;
	tdpt_pkg::kind_t      f_kind;
	logic [NUM_WIDTH-1:0] f_num;
	logic                 q_valid;
	logic                 q_stall;
	logic [QW-1:0]        q_wdata;
	logic [QW-1:0]        q_rdata;
	tdpt_pkg::kind_t      q_kind;
	logic [NUM_WIDTH-1:0] q_num;

	tdpt_front #(
		.NUM_WIDTH(NUM_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.number   (number),
		.f_valid  (f_valid),
		.f_stall  (f_stall),
		.f_kind   (f_kind),
		.f_num    (f_num)
	);

	assign q_wdata = {f_kind, f_num};

	tdpt_queue #(
		.DATA_WIDTH(QW)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (f_valid),
		.wr_stall (f_stall),
		.wr_data  (q_wdata),
		.rd_valid (q_valid),
		.rd_stall (q_stall),
		.rd_data  (q_rdata)
	);

	assign q_kind = tdpt_pkg::kind_t'(q_rdata[QW-1:NUM_WIDTH]);
	assign q_num  = q_rdata[NUM_WIDTH-1:0];

	tdpt_back #(
		.NUM_WIDTH(NUM_WIDTH)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_stall     (q_stall),
		.q_kind      (q_kind),
		.q_num       (q_num),
		.res_valid   (out_valid),
		.res_stall   (out_stall),
		.res_verdict (verdict),
		.res_divisor (divisor)
	);

endmodule
`default_nettype wire
